@@ src/rbb_pkg.sv @@
`timescale 1ns / 1ps
package rbb_pkg;

    // Packed pixel: alpha in the top byte, then blue, green, red.
    typedef logic [31:0] t_pix;

    // Width of the sums and the reciprocal scaling of the mean divider.
    localparam int SUM_W   = 12;
    localparam int RECIP_K = 18;
    localparam int RECIP_W = RECIP_K + 1;

    // Comparison widths for column and row limits.
    localparam int XW = 14;
    localparam int YW = 17;

    // Register indexes of the configuration port.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Request to the mean unit: which window cells count, and the passed fields.
    typedef struct packed {
        logic [8:0] mask;
        logic [7:0] alpha;
        logic       last;
    } t_mean_req;

    // One finished result.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } t_mean_res;

    // Rounded-up reciprocal of the cell count, scaled by 2**RECIP_K.
    function automatic logic [RECIP_W-1:0] f_recip(input logic [3:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            4'd2:    m = RECIP_W'(131072);
            4'd3:    m = RECIP_W'(87382);
            4'd4:    m = RECIP_W'(65536);
            4'd5:    m = RECIP_W'(52429);
            4'd6:    m = RECIP_W'(43691);
            4'd7:    m = RECIP_W'(37450);
            4'd8:    m = RECIP_W'(32768);
            4'd9:    m = RECIP_W'(29128);
            default: m = RECIP_W'(262144);
        endcase
        return m;
    endfunction

endpackage

@@ src/rbb_in_if.sv @@
`timescale 1ns / 1ps
interface rbb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;

    modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
    modport sink   (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

@@ src/rbb_out_if.sv @@
`timescale 1ns / 1ps
interface rbb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       frame_end;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, frame_end,
                    input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha, frame_end,
                    output ready);
endinterface

@@ src/rbb_ram.sv @@
`timescale 1ns / 1ps
module rbb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

@@ src/rbb_mean.sv @@
`timescale 1ns / 1ps
module rbb_mean (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  rbb_pkg::t_mean_req   i_req,
    input  rbb_pkg::t_pix        i_win [9],
    output logic                 o_done,
    output rbb_pkg::t_mean_res   o_res
);
    import rbb_pkg::*;

    logic [SUM_W-1:0]       n_sum [3];
    logic [3:0]             n_cnt;
    logic [SUM_W-1:0]       r_sum [3];
    logic [RECIP_W-1:0]     r_recip;
    logic [7:0]             r_alpha;
    logic                   r_last;
    logic                   r_stage;
    logic [SUM_W+RECIP_W-1:0] prod [3];

    // Sum the selected window cells per color and count them.
    always_comb begin
        n_sum = '{default: '0};
        n_cnt = '0;
        for (int i = 0; i < 9; i++) begin
            if (i_req.mask[i]) begin
                n_sum[0] = n_sum[0] + SUM_W'(i_win[i][7:0]);
                n_sum[1] = n_sum[1] + SUM_W'(i_win[i][15:8]);
                n_sum[2] = n_sum[2] + SUM_W'(i_win[i][23:16]);
                n_cnt    = n_cnt + 4'd1;
            end
        end
    end

    // Divide by the count through its scaled reciprocal.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod[k] = (SUM_W+RECIP_W)'(r_sum[k]) * (SUM_W+RECIP_W)'(r_recip);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 1'b0;
            o_done  <= 1'b0;
        end else begin
            r_stage <= i_start;
            o_done  <= r_stage;
        end
        if (i_start) begin
            r_sum   <= n_sum;
            r_recip <= f_recip(n_cnt);
            r_alpha <= i_req.alpha;
            r_last  <= i_req.last;
        end
        if (r_stage) begin
            o_res.red   <= prod[0][RECIP_K+7:RECIP_K];
            o_res.green <= prod[1][RECIP_K+7:RECIP_K];
            o_res.blue  <= prod[2][RECIP_K+7:RECIP_K];
            o_res.alpha <= r_alpha;
            o_res.last  <= r_last;
        end
    end

endmodule

@@ src/rgba_box_blur_3x3.sv @@
`timescale 1ns / 1ps
// Streaming 3x3 box blur over RGBA pixels in raster order. Each result is the
// truncated mean of red, green and blue over the in-frame cells of a pixel's
// 3x3 neighborhood, with the center alpha passed through; results trail the
// input by about one row, and frame_end marks the last one of a frame. One
// pixel request is taken at a time: it is accepted with the line store read,
// written back with the window shift, and followed by a dispatch check; each
// result it releases passes through dispatch, the mean unit's start, sum and
// reciprocal multiply, and output, where it may wait on an output stall. The
// pace is set by the single two-stage mean unit shared by all results. The
// line stores start undefined and need no clearing pass.
module rgba_box_blur_3x3 #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rbb_in_if.sink            i_pix,
    rbb_out_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import rbb_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW = $clog2(2 * MAX_WIDTH);

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_NEXT, S_WAIT, S_OUT} t_state;

    t_state        r_state;
    logic [11:0]   r_frame_width;
    logic [12:0]   r_frame_height;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    t_pix          r_win [9];
    t_pix          r_pix;
    logic [AW-1:0] r_wr_addr;
    logic [3:0]    r_pend;
    logic [1:0]    r_rv;
    logic [1:0]    r_cv;
    logic          r_out_valid;
    t_mean_req     r_req;
    logic          r_start;

    logic [XW-1:0] w_last;
    logic [YW-1:0] h_last;
    logic [CW-1:0] c_eff;
    logic          last_col;
    logic          last_row;
    logic [AW-1:0] own_addr;
    logic [AW-1:0] other_addr;
    logic          in_acc;
    t_pix          rd_own;
    t_pix          rd_other;
    logic          mean_done;
    t_mean_res     mean_res;
    t_mean_req     n_req;
    logic [3:0]    n_pick;
    logic [1:0]    rlo_ok;
    logic [2:0]    clo_ok;
    logic [1:0]    crow;
    logic [1:0]    ccol;

    // Configuration registers.
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 12'd640;
            r_frame_height <= 13'd480;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_WIDTH:  r_frame_width  <= pwdata[11:0];
                REG_HEIGHT: r_frame_height <= pwdata[12:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WIDTH:  prdata = 32'(r_frame_width);
            REG_HEIGHT: prdata = 32'(r_frame_height);
            default:    prdata = '0;
        endcase
    end

    // Last column and row indexes, with zero and oversized sizes clamped.
    always_comb begin
        if (r_frame_width == '0) begin
            w_last = '0;
        end else if (XW'(r_frame_width) > XW'(MAX_WIDTH)) begin
            w_last = XW'(MAX_WIDTH - 1);
        end else begin
            w_last = XW'(r_frame_width) - XW'(1);
        end
        if (r_frame_height == '0) begin
            h_last = '0;
        end else if (YW'(r_frame_height) > YW'(MAX_HEIGHT)) begin
            h_last = YW'(MAX_HEIGHT - 1);
        end else begin
            h_last = YW'(r_frame_height) - YW'(1);
        end
        if (XW'(r_col) > XW'(MAX_WIDTH - 1)) begin
            c_eff = CW'(MAX_WIDTH - 1);
        end else begin
            c_eff = r_col;
        end
    end

    assign last_col   = XW'(c_eff) >= w_last;
    assign last_row   = YW'(r_row) >= h_last;
    assign own_addr   = r_row[0] ? AW'(MAX_WIDTH) + AW'(c_eff) : AW'(c_eff);
    assign other_addr = r_row[0] ? AW'(c_eff) : AW'(MAX_WIDTH) + AW'(c_eff);
    assign in_acc     = i_pix.valid && i_pix.ready;
    assign i_pix.ready = (r_state == S_IDLE);

    // Line store: row parity selects the bank, column the entry.
    rbb_ram #(
        .WIDTH (32),
        .DEPTH (2 * MAX_WIDTH)
    ) u_ram (
        .i_clk       (i_clk),
        .i_we        (r_state == S_LOAD),
        .i_wr_addr   (r_wr_addr),
        .i_wr_data   (r_pix),
        .i_rd_addr_a (own_addr),
        .i_rd_addr_b (other_addr),
        .o_rd_data_a (rd_own),
        .o_rd_data_b (rd_other)
    );

    // Select the earliest pending result and build its cell mask.
    always_comb begin
        n_pick = r_pend & (~r_pend + 4'd1);
        rlo_ok = (n_pick[2] || n_pick[3]) ? 2'b10 : 2'b11;
        clo_ok = (n_pick[1] || n_pick[3]) ? 3'b110 : 3'b111;
        crow   = (n_pick[2] || n_pick[3]) ? 2'd2 : 2'd1;
        ccol   = (n_pick[1] || n_pick[3]) ? 2'd2 : 2'd1;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_req.mask[i*3+j] = ((i == 2) || (r_rv[i] && ((i == 1) || rlo_ok[0]))) &&
                                    ((j == 2) || (r_cv[j] && clo_ok[j]));
            end
        end
        n_req.alpha = r_win[4'(crow) * 4'd3 + 4'(ccol)][31:24];
        n_req.last  = n_pick[3];
    end

    rbb_mean u_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_req   (r_req),
        .i_win   (r_win),
        .o_done  (mean_done),
        .o_res   (mean_res)
    );

    assign o_res.valid     = r_out_valid;
    assign o_res.out_red   = mean_res.red;
    assign o_res.out_green = mean_res.green;
    assign o_res.out_blue  = mean_res.blue;
    assign o_res.out_alpha = mean_res.alpha;
    assign o_res.frame_end = mean_res.last;

    // Sequencer: read, write back and shift, then release each result in order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_win       <= '{default: '0};
            r_pend      <= '0;
            r_out_valid <= 1'b0;
            r_start     <= 1'b0;
        end else begin
            r_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_pix     <= {i_pix.in_alpha, i_pix.in_blue,
                                      i_pix.in_green, i_pix.in_red};
                        r_wr_addr <= own_addr;
                        r_rv      <= {YW'(r_row) >= YW'(1), YW'(r_row) >= YW'(2)};
                        r_cv      <= {XW'(c_eff) >= XW'(1), XW'(c_eff) >= XW'(2)};
                        r_pend    <= {last_row && last_col,
                                      last_row && (c_eff != '0),
                                      (r_row != '0) && last_col,
                                      (r_row != '0) && (c_eff != '0)};
                        if (last_col) begin
                            r_col <= '0;
                            r_row <= last_row ? '0 : r_row + RW'(1);
                        end else begin
                            r_col <= c_eff + CW'(1);
                        end
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    for (int i = 0; i < 3; i++) begin
                        r_win[i*3]   <= r_win[i*3+1];
                        r_win[i*3+1] <= r_win[i*3+2];
                    end
                    r_win[2] <= rd_own;
                    r_win[5] <= rd_other;
                    r_win[8] <= r_pix;
                    r_state  <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_pend == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_req   <= n_req;
                        r_start <= 1'b1;
                        r_pend  <= r_pend & ~n_pick;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (mean_done) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_res.ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_NEXT;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    // A result is never offered while a new pixel request can be taken.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_out_valid && i_pix.ready))
        else $error("result pending while input is ready");

    // The frame's last result leaves the counters at the frame start.
    a_frame_end_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_res.frame_end) |-> (r_col == '0 && r_row == '0))
        else $error("frame end without counter wrap");

    // The mean unit finishes only while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mean_done |-> (r_state == S_WAIT))
        else $error("mean result outside wait state");
`endif

endmodule

@@ tb/rgba_box_blur_3x3_tb.sv @@
`timescale 1ns / 1ps
module rgba_box_blur_3x3_tb;
    import rbb_pkg::*;

    localparam int MAXW = 2048;
    localparam int MAXH = 4096;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    rbb_in_if  pix_if ();
    rbb_out_if res_if ();

    rgba_box_blur_3x3 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if.sink),
        .o_res   (res_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the filter state.
    int unsigned shadow_width;
    int unsigned shadow_height;
    t_pix        shadow_lines [2*MAXW];
    t_pix        shadow_win [3][3];
    int unsigned shadow_col;
    int unsigned shadow_row;

    t_pix      pixel_queue [$];
    t_mean_res blur_queue [$];
    int        error_count = 0;
    bit        idle_enable = 1'b1;
    bit        long_stall_req = 1'b0;
    int        send_gap = 0;
    int        recv_gap = 0;
    int        stall_left = 0;

    // Mean over the valid cells of the window rows rlo..2 and columns clo..chi.
    function automatic t_mean_res window_mean(input bit rv [3], input bit cv [3],
                                              input int rlo, input int clo, input int chi,
                                              input int crow, input int ccol,
                                              input bit last);
        int unsigned sum [3];
        int unsigned cnt;
        t_mean_res   res;
        sum = '{0, 0, 0};
        cnt = 0;
        for (int i = rlo; i <= 2; i++) begin
            if (rv[i]) begin
                for (int j = clo; j <= chi; j++) begin
                    if (cv[j]) begin
                        for (int k = 0; k < 3; k++)
                            sum[k] += (shadow_win[i][j] >> (8 * k)) & 8'hFF;
                        cnt++;
                    end
                end
            end
        end
        if (cnt == 0)
            cnt = 1;
        res.red   = 8'(sum[0] / cnt);
        res.green = 8'(sum[1] / cnt);
        res.blue  = 8'(sum[2] / cnt);
        res.alpha = shadow_win[crow][ccol][31:24];
        res.last  = last;
        return res;
    endfunction

    // Advance the shadow state by one accepted pixel and queue the blurred results.
    task automatic predict_blur(input t_pix p);
        int unsigned w, h, c, r, own, other;
        bit          last_col, last_row;
        bit          rv [3];
        bit          cv [3];
        w = shadow_width;
        h = shadow_height;
        c = shadow_col;
        r = shadow_row;
        if (w == 0) w = 1;
        if (w > MAXW) w = MAXW;
        if (h == 0) h = 1;
        if (h > MAXH) h = MAXH;
        if (c >= MAXW) c = MAXW - 1;
        last_col = (c >= w - 1);
        last_row = (r >= h - 1);
        own   = (r & 1) * MAXW + c;
        other = ((r + 1) & 1) * MAXW + c;
        for (int i = 0; i < 3; i++) begin
            shadow_win[i][0] = shadow_win[i][1];
            shadow_win[i][1] = shadow_win[i][2];
        end
        shadow_win[0][2] = shadow_lines[own];
        shadow_win[1][2] = shadow_lines[other];
        shadow_win[2][2] = p;
        shadow_lines[own] = p;
        rv = '{r >= 2, r >= 1, 1'b1};
        cv = '{c >= 2, c >= 1, 1'b1};
        if (r >= 1) begin
            if (c >= 1)
                blur_queue.push_back(window_mean(rv, cv, 0, 0, 2, 1, 1, 1'b0));
            if (last_col)
                blur_queue.push_back(window_mean(rv, cv, 0, 1, 2, 1, 2, 1'b0));
        end
        if (last_row) begin
            if (c >= 1)
                blur_queue.push_back(window_mean(rv, cv, 1, 0, 2, 2, 1, 1'b0));
            if (last_col)
                blur_queue.push_back(window_mean(rv, cv, 1, 1, 2, 2, 2, 1'b1));
        end
        if (last_col) begin
            shadow_col = 0;
            shadow_row = last_row ? 0 : ((r + 1) & 12'hFFF);
        end else begin
            shadow_col = (c + 1) & 11'h7FF;
        end
    endtask

    // Pixel driver: feeds requests from the pending queue with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else begin
            if (pix_if.valid && pix_if.ready)
                predict_blur({pix_if.in_alpha, pix_if.in_blue, pix_if.in_green,
                              pix_if.in_red});
            if (!pix_if.valid || pix_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    pix_if.valid <= 1'b0;
                end else if (pixel_queue.size() > 0) begin
                    t_pix p;
                    p = pixel_queue.pop_front();
                    pix_if.valid    <= 1'b1;
                    pix_if.in_red   <= p[7:0];
                    pix_if.in_green <= p[15:8];
                    pix_if.in_blue  <= p[23:16];
                    pix_if.in_alpha <= p[31:24];
                    if (idle_enable && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 3);
                end else begin
                    pix_if.valid <= 1'b0;
                end
            end
        end
    end

    initial begin
        pix_if.valid    = 1'b0;
        pix_if.in_red   = '0;
        pix_if.in_green = '0;
        pix_if.in_blue  = '0;
        pix_if.in_alpha = '0;
        res_if.ready    = 1'b0;
    end

    // Result monitor: compares each accepted result and throttles ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                t_mean_res got, want;
                got = '{res_if.out_red, res_if.out_green, res_if.out_blue,
                        res_if.out_alpha, res_if.frame_end};
                if (blur_queue.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    error_count++;
                end else begin
                    want = blur_queue.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.alpha !== want.alpha ||
                        got.last !== want.last) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, got);
                        error_count++;
                    end
                end
            end
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                stall_left = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                if (idle_enable && $urandom_range(0, 5) == 0)
                    recv_gap = $urandom_range(1, 3);
            end
        end
    end

    // Register write over the configuration port; the shadow copy follows it.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx) << 2;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_WIDTH)
            shadow_width = value & 12'hFFF;
        else
            shadow_height = value & 13'h1FFF;
    endtask

    task automatic wait_drained();
        while (pixel_queue.size() > 0 || pix_if.valid || blur_queue.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_size(input int w, input int h);
        wait_drained();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    task automatic push_frames(input int w, input int h, input int frames);
        for (int f = 0; f < frames; f++)
            for (int n = 0; n < w * h; n++)
                pixel_queue.push_back($urandom());
    endtask

    initial begin
        int total;
        shadow_width  = 640;
        shadow_height = 480;
        shadow_col    = 0;
        shadow_row    = 0;
        foreach (shadow_lines[i]) shadow_lines[i] = '0;
        foreach (shadow_win[i, j]) shadow_win[i][j] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single pixel, all-ones and all-zeros values.
        set_size(1, 1);
        pixel_queue.push_back(32'hFFFF_FFFF);
        pixel_queue.push_back(32'h0000_0000);
        // One column and one row frames.
        set_size(1, 4);
        for (int n = 0; n < 4; n++)
            pixel_queue.push_back(n[0] ? 32'hFFFF_FFFF : 32'h0000_0000);
        set_size(4, 1);
        for (int n = 0; n < 4; n++)
            pixel_queue.push_back(n[0] ? 32'h00FF_00FF : 32'hFF00_FF00);
        // A full 3x3 neighborhood with extreme values.
        set_size(3, 3);
        for (int n = 0; n < 9; n++)
            pixel_queue.push_back((n == 4) ? 32'h0000_0000 : 32'hFFFF_FFFF);

        // Long output stall while the sender keeps offering pixels.
        set_size(16, 6);
        long_stall_req = 1'b1;
        push_frames(16, 6, 1);

        // Random frames of small sizes.
        total = 115;
        while (total < 420) begin
            int w, h, frames;
            w = $urandom_range(1, 20);
            h = $urandom_range(1, 8);
            frames = $urandom_range(1, 2);
            set_size(w, h);
            push_frames(w, h, frames);
            total += w * h * frames;
        end

        // Zero sizes act as one, then the last part with no idling.
        set_size(0, 3);
        push_frames(1, 3, 1);
        set_size(3, 0);
        push_frames(3, 1, 1);
        set_size(2, 2);
        push_frames(2, 2, 3);
        set_size(2, 2);
        idle_enable = 1'b0;
        push_frames(2, 2, 1);
        set_size(5, 3);
        push_frames(5, 3, 1);

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (error_count == 0 && blur_queue.size() == 0) begin
            $display("rgba_box_blur_3x3 test passed");
        end else begin
            $display("rgba_box_blur_3x3 test failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #400000;
        $display("rgba_box_blur_3x3 test failed");
        $finish;
    end

endmodule
